### rtl/core/insertion_sorter_assert.svh
// Assertion macros used by the insertion sorter RTL.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISORT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, checked outside reset.
`define ISORT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

### rtl/core/isort_pkg.sv
// Types shared by the insertion sorter modules.
package isort_pkg;

    typedef struct packed {
        logic signed [31:0] value;
        logic               batch_end;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               final_result;
        logic               overflowed;
    } t_out_req;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // insert the broadcast value
        logic shl;   // shift toward cell 0 (drain)
    } t_cell_ctl;

endpackage

### rtl/core/isort_cell.sv
// One cell of the insertion chain: holds one sorted entry.
module isort_cell (
    input  logic                  i_clk,
    input  isort_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_occupied,
    input  logic signed [31:0]    i_value,
    input  logic                  i_left_less,
    input  logic signed [31:0]    i_left_data,
    input  logic signed [31:0]    i_right_data,
    output logic                  o_less,
    output logic signed [31:0]    o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    // Entry stays put while it is smaller than the new value.
    assign o_less = i_occupied && (r_data < i_value);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (!o_less) begin
                n_data = i_left_less ? i_value : i_left_data;
            end
        end else if (i_ctl.shl) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

### rtl/core/insertion_sorter.sv
// Top level of the insertion sorter: cell chain plus fill/drain control.
//
// Insertion sorter. Values arrive one request at a time and are inserted
// into a row of CAPACITY cells that always holds the batch in ascending
// order: every cell compares its entry with the broadcast value at once,
// and the cells at and after the insertion point take their left neighbor's
// entry. An equal value goes ahead of the stored equal ones.
// When the row is full, further values are dropped and the overflow flag is
// raised for the batch. The request marked batch_end is inserted like any
// other, and then the row drains through cell 0, one result per cycle while
// the output is not stalled; final_result marks the greatest value. During
// the drain the input is stalled. After the final result the block is
// empty and takes the next batch at once.

`include "insertion_sorter_assert.svh"

module insertion_sorter #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  isort_pkg::t_in_req   i_in_req,
    // result requests
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output isort_pkg::t_out_req  o_out_req
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_FILL,
        S_DRAIN
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_fill;     // entries held; counts down while draining
    logic                r_ovf;

    logic                in_acc;
    logic                out_acc;
    logic                full;
    isort_pkg::t_cell_ctl ctl;

    logic               [CAPACITY-1:0] occ;
    logic               [CAPACITY-1:0] less;
    logic signed [31:0] data [CAPACITY];

    assign full    = (r_fill == CNT_W'(CAPACITY));
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Drop on full: the chain is left alone and only the flag moves.
    assign ctl.ins = in_acc && !full;
    assign ctl.shl = out_acc;

    assign o_in_stall  = (r_state == S_DRAIN);
    assign o_out_valid = (r_state == S_DRAIN);

    // Cell 0 is the head of the sorted row.
    assign o_out_req.sorted_value = data[0];
    assign o_out_req.final_result = (r_fill == CNT_W'(1));
    assign o_out_req.overflowed   = r_ovf;

    // ---- cell chain ----
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic               left_less;
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        assign occ[g] = (CNT_W'(g) < r_fill);

        if (g == 0) begin : g_head
            // Nothing to the left: the head takes the new value if not less.
            assign left_less = 1'b1;
            assign left_data = i_in_req.value;
        end else begin : g_mid
            assign left_less = less[g-1];
            assign left_data = data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_data = '0;
        end else begin : g_body
            assign right_data = data[g+1];
        end

        isort_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (occ[g]),
            .i_value      (i_in_req.value),
            .i_left_less  (left_less),
            .i_left_data  (left_data),
            .i_right_data (right_data),
            .o_less       (less[g]),
            .o_data       (data[g])
        );
    end

    // ---- control: fill, then drain ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            case (r_state)
                S_FILL: begin
                    if (in_acc) begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                        if (i_in_req.batch_end) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    if (out_acc) begin
                        r_fill <= r_fill - CNT_W'(1);
                        if (r_fill == CNT_W'(1)) begin
                            r_state <= S_FILL;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

    // ---- assertions ----
    `ISORT_ASSERT_NOW(a_drain_nonempty, r_state == S_DRAIN, r_fill != '0)
    `ISORT_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(CAPACITY))
    `ISORT_ASSERT_NEXT(a_insert_count, ctl.ins, r_fill == $past(r_fill) + CNT_W'(1))
    `ISORT_ASSERT_NEXT(a_final_clears, out_acc && o_out_req.final_result,
                       r_state == S_FILL && r_fill == '0 && !r_ovf)

endmodule
